/* design/assert_macros.svh */
// Assertion macros for the timer table RTL.
// Uses clk and rst_n of the including module; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define DTT_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer table check failed");

// antecedent holds -> consequent holds in the next cycle
`define DTT_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer table check failed");

`endif

/* design/dtt_pkg.sv */
// Types and constants for the delay request timer table.
// No dependencies; imported by every module of the block.
`default_nettype none

package dtt_pkg;

    localparam int unsigned RATE_W        = 14;
    localparam logic [RATE_W-1:0] RATE_RESET = 14'd100;
    localparam int unsigned MS_PER_SECOND = 1000;
    // ceil(2^38 / 1000); (x * RECIP_1000) >> 38 equals x / 1000 for any 32-bit x
    localparam int unsigned RECIP_W       = 29;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 29'h1062_4DD3;
    localparam int unsigned RECIP_SHIFT   = 38;
    localparam int unsigned MAX_RESULTS   = 32;
    localparam int unsigned QUEUE_DEPTH   = 2;
    localparam int unsigned ADDR_W        = 3;

    // register select is paddr[2]
    localparam logic REG_TICK_RATE = 1'b0;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_DELAY  = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_IGNORE = 3'd3;

    localparam logic [1:0] KIND_DELAY  = 2'd0;
    localparam logic [1:0] KIND_COUNT  = 2'd1;
    localparam logic [1:0] KIND_EXPIRY = 2'd2;
    localparam logic [1:0] KIND_REJECT = 2'd3;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] wait_ms;
        logic [15:0] requester;
    } req_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] dest_process;
        logic [31:0] value;
        logic        last;
    } rsp_word_t;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_DELAY,
        CMD_READ,
        CMD_REJECT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [15:0] requester;
        logic [31:0] ticks;
    } cmd_t;

    typedef struct packed {
        logic [31:0] req_tag;
        logic [15:0] owner;
        logic [31:0] deadline;
    } slot_t;

endpackage

`default_nettype wire

/* design/dtt_front.sv */
// Front end: accepts request words, decodes them and converts ms to ticks.
// Depends on dtt_pkg; feeds dtt_queue.
`default_nettype none

module dtt_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [dtt_pkg::RATE_W-1:0]   tick_rate_hz,
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire dtt_pkg::req_word_t           req_word,
    output dtt_pkg::cmd_t                     cmd,
    output logic                              cmd_push,
    input  wire logic                         cmd_full
);
    import dtt_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } fstate_t;

    localparam int unsigned PROD_W = 32 + RECIP_W;

    fstate_t             state_reg;
    cmd_t                cmd_reg;
    logic [31:0]         prod_reg;

    logic [45:0]         product;
    logic [PROD_W-1:0]   recip_prod;

    // ms * rate, wrapped to 32 bits below
    assign product    = {14'b0, req_word.wait_ms} * {32'b0, tick_rate_hz};

    // divide by 1000 through the reciprocal, from the product registered at the accept
    assign recip_prod = {{RECIP_W{1'b0}}, prod_reg} * {32'b0, RECIP_1000};

    assign req_stall = (state_reg != F_IDLE);
    assign cmd_push  = (state_reg == F_PUSH) && !cmd_full;
    assign cmd       = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cmd_reg   <= '0;
            prod_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (req_valid)
                    begin
                        cmd_reg.requester <= req_word.requester;
                        cmd_reg.ticks     <= '0;
                        case (req_word.opcode)
                            OP_TICK:
                            begin
                                cmd_reg.op <= CMD_TICK;
                                state_reg  <= F_PUSH;
                            end
                            OP_DELAY:
                            begin
                                cmd_reg.op <= CMD_DELAY;
                                prod_reg   <= product[31:0];
                                state_reg  <= F_DIV;
                            end
                            OP_READ:
                            begin
                                cmd_reg.op <= CMD_READ;
                                state_reg  <= F_PUSH;
                            end
                            OP_IGNORE:
                            begin
                                state_reg  <= F_IDLE;
                            end
                            default:
                            begin
                                cmd_reg.op <= CMD_REJECT;
                                state_reg  <= F_PUSH;
                            end
                        endcase
                    end
                end
                F_DIV:
                begin
                    cmd_reg.ticks <= 32'(recip_prod[PROD_W-1:RECIP_SHIFT]);
                    state_reg     <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!cmd_full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* design/dtt_queue.sv */
// Short command queue between front end and back end.
// Depends on dtt_pkg for the command type.
`default_nettype none

module dtt_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire dtt_pkg::cmd_t  push_cmd,
    output logic                full,
    input  wire logic           pop,
    output dtt_pkg::cmd_t       head,
    output logic                empty
);
    import dtt_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              ent_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;

    assign full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = ent_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* design/dtt_back.sv */
// Back end: tick count, slot table and result word register.
// Depends on dtt_pkg; takes commands from dtt_queue.
`default_nettype none

module dtt_back #(
    parameter int unsigned SLOTS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dtt_pkg::cmd_t      head,
    input  wire logic               q_empty,
    output logic                    q_pop,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output dtt_pkg::rsp_word_t      rsp_word
);
    import dtt_pkg::*;

    localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned IDX_W  = $clog2(SLOTS + 1);
    localparam int unsigned N_W    = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_FLUSH
    } bstate_t;

    bstate_t             state_reg;
    logic [31:0]         count_reg;
    logic [31:0]         next_id_reg;
    logic [SLOTS-1:0]    active_reg;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [SLOT_W-1:0]   chk_idx_reg;
    logic                chk_valid_reg;
    slot_t               rdata_reg;
    rsp_word_t           hold_reg;
    logic                hold_valid_reg;
    logic [N_W-1:0]      n_reg;
    logic                rsp_valid_reg;
    rsp_word_t           rsp_reg;

    slot_t               slot_mem [SLOTS];

    logic [SLOTS-1:0]    free_vec;
    logic [SLOTS-1:0]    lowest_free;
    logic                any_free;
    logic [SLOT_W-1:0]   free_idx;
    logic                out_free;
    logic                due;
    logic                blocked;
    logic                scan_end;
    logic                mem_we;
    logic                mem_rd;
    slot_t               mem_wdata;
    logic                rsp_load;
    rsp_word_t           load_word;

    // lowest free slot: isolate lowest set bit, then encode
    assign free_vec    = ~active_reg;
    assign lowest_free = free_vec & (~free_vec + 1'b1);
    assign any_free    = |free_vec;

    always_comb
    begin
        free_idx = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (lowest_free[i])
            begin
                free_idx = free_idx | SLOT_W'(i);
            end
        end
    end

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;

    // scan: read stage at rd_idx, check stage at chk_idx
    assign due      = chk_valid_reg && active_reg[chk_idx_reg]
                      && (rdata_reg.deadline <= count_reg)
                      && (n_reg < N_W'(MAX_RESULTS));
    // an expiry is held in hold_reg until the next is found, so the final one can carry last
    assign blocked  = due && hold_valid_reg && !out_free;
    assign scan_end = (rd_idx_reg == IDX_W'(SLOTS)) && !chk_valid_reg;
    assign mem_rd   = (state_reg == B_SCAN) && !blocked && !scan_end
                      && (rd_idx_reg < IDX_W'(SLOTS));

    assign mem_wdata.req_tag  = next_id_reg;
    assign mem_wdata.owner    = head.requester;
    assign mem_wdata.deadline = count_reg + head.ticks;

    always_comb
    begin
        q_pop     = 1'b0;
        mem_we    = 1'b0;
        rsp_load  = 1'b0;
        load_word = '0;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    load_word.dest_process = head.requester;
                    load_word.last         = 1'b1;
                    case (head.op)
                        CMD_TICK:
                        begin
                            q_pop = 1'b1;
                        end
                        CMD_DELAY:
                        begin
                            q_pop           = out_free;
                            rsp_load        = out_free;
                            mem_we          = out_free && any_free;
                            load_word.kind  = KIND_DELAY;
                            load_word.value = any_free ? next_id_reg : '0;
                        end
                        CMD_READ:
                        begin
                            q_pop           = out_free;
                            rsp_load        = out_free;
                            load_word.kind  = KIND_COUNT;
                            load_word.value = count_reg;
                        end
                        default:
                        begin
                            q_pop          = out_free;
                            rsp_load       = out_free;
                            load_word.kind = KIND_REJECT;
                        end
                    endcase
                end
            end
            B_SCAN:
            begin
                rsp_load  = due && hold_valid_reg && out_free;
                load_word = hold_reg;
            end
            B_FLUSH:
            begin
                rsp_load       = hold_valid_reg && out_free;
                load_word      = hold_reg;
                load_word.last = 1'b1;
            end
            default:
            begin
                rsp_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[free_idx] <= mem_wdata;
        end
        if (mem_rd)
        begin
            rdata_reg <= slot_mem[rd_idx_reg[SLOT_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            count_reg      <= '0;
            next_id_reg    <= 32'd1;
            active_reg     <= '0;
            rd_idx_reg     <= '0;
            chk_idx_reg    <= '0;
            chk_valid_reg  <= 1'b0;
            hold_reg       <= '0;
            hold_valid_reg <= 1'b0;
            n_reg          <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
        end
        else
        begin
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
                rsp_reg       <= load_word;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                B_IDLE:
                begin
                    if (q_pop && (head.op == CMD_TICK))
                    begin
                        count_reg      <= count_reg + 1'b1;
                        rd_idx_reg     <= '0;
                        chk_valid_reg  <= 1'b0;
                        hold_valid_reg <= 1'b0;
                        n_reg          <= '0;
                        state_reg      <= B_SCAN;
                    end
                    if (mem_we)
                    begin
                        active_reg[free_idx] <= 1'b1;
                        next_id_reg          <= next_id_reg + 1'b1;
                    end
                end
                B_SCAN:
                begin
                    if (scan_end)
                    begin
                        state_reg <= B_FLUSH;
                    end
                    else if (!blocked)
                    begin
                        if (due)
                        begin
                            hold_reg.kind         <= KIND_EXPIRY;
                            hold_reg.dest_process <= rdata_reg.owner;
                            hold_reg.value        <= rdata_reg.req_tag;
                            hold_reg.last         <= 1'b0;
                            hold_valid_reg        <= 1'b1;
                            active_reg[chk_idx_reg] <= 1'b0;
                            n_reg                 <= n_reg + 1'b1;
                        end
                        if (rd_idx_reg < IDX_W'(SLOTS))
                        begin
                            chk_idx_reg   <= rd_idx_reg[SLOT_W-1:0];
                            chk_valid_reg <= 1'b1;
                            rd_idx_reg    <= rd_idx_reg + 1'b1;
                        end
                        else
                        begin
                            chk_valid_reg <= 1'b0;
                        end
                    end
                end
                B_FLUSH:
                begin
                    if (!hold_valid_reg || out_free)
                    begin
                        hold_valid_reg <= 1'b0;
                        state_reg      <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* design/delay_request_timer_table.sv */
// Top level of the delay request timer table: APB register, front, queue, back.
// Depends on dtt_pkg, dtt_front, dtt_queue, dtt_back and assert_macros.svh.
//
//   channel   direction  handshake            word
//   req       in         req_valid/req_stall  req_word (opcode, wait_ms, requester)
//   rsp       out        rsp_valid/rsp_stall  rsp_word (kind, dest_process, value, last)
//   apb       in/out     psel/penable/pready  tick_rate_hz at paddr 0
//
// Delay word: the front end accepts it, multiplies by 1/1000, then pushes it.
// Tick word: the back end scans all slots, one slot read per cycle unless blocked.
// Read and reject words: the front end accepts and pushes them; ignored: no result.
// Delay, read and reject results load as the back end pops. No clearing pass after reset.
// A two-entry queue lets the front end take words while the back end scans;
// rsp_stall holds the result register and pauses the scan only when a
// further expiry is found while one is held.
`default_nettype none

`include "assert_macros.svh"

module delay_request_timer_table #(
    parameter int unsigned SLOTS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [dtt_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  wire logic                         req_valid,
    output logic                              req_stall,
    input  wire dtt_pkg::req_word_t           req_word,
    output logic                              rsp_valid,
    input  wire logic                         rsp_stall,
    output dtt_pkg::rsp_word_t                rsp_word
);
    import dtt_pkg::*;

    logic [RATE_W-1:0]  rate_reg;
    cmd_t               front_cmd;
    logic               cmd_push;
    logic               cmd_full;
    cmd_t               head;
    logic               cmd_pop;
    logic               cmd_empty;
    logic               req_fire;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TICK_RATE) ? 32'(rate_reg) : '0;
    assign req_fire = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg <= RATE_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_TICK_RATE))
        begin
            rate_reg <= pwdata[RATE_W-1:0];
        end
    end

    dtt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_rate_hz (rate_reg),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req_word     (req_word),
        .cmd          (front_cmd),
        .cmd_push     (cmd_push),
        .cmd_full     (cmd_full)
    );

    dtt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (front_cmd),
        .full     (cmd_full),
        .pop      (cmd_pop),
        .head     (head),
        .empty    (cmd_empty)
    );

    dtt_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (cmd_empty),
        .q_pop     (cmd_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

    `DTT_ASSERT_IMP(a_no_push_when_full, cmd_push, !cmd_full)
    `DTT_ASSERT_IMP(a_no_pop_when_empty, cmd_pop, !cmd_empty)
    `DTT_ASSERT_IMP(a_single_last, rsp_valid && (rsp_word.kind != KIND_EXPIRY), rsp_word.last)
    `DTT_ASSERT_NXT(a_front_busy, req_fire && (req_word.opcode != OP_IGNORE), req_stall)

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking bench for delay_request_timer_table: directed words, then random
// phases under varied tick rates and handshake idling, checked against a shadow table.
// Depends on dtt_pkg and the block's RTL only.
module tb;
    import dtt_pkg::*;

    localparam int SLOTS         = 32;
    localparam int DRAIN_CYCLES  = 64;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SEGMENTS      = 9;
    localparam int SEG_WORDS     = 34;
    localparam int FILL_WORDS    = 34;
    localparam int DIRECTED_ROWS = 26;

    localparam logic [2:0] OP_BAD_4 = 3'd4;
    localparam logic [2:0] OP_BAD_5 = 3'd5;
    localparam logic [2:0] OP_BAD_6 = 3'd6;
    localparam logic [2:0] OP_BAD_7 = 3'd7;
    localparam logic [ADDR_W-1:0] ADDR_TICK_RATE = {REG_TICK_RATE, 2'b00};

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              req_valid;
    logic              req_stall;
    req_word_t         req_word;
    logic              rsp_valid;
    logic              rsp_stall;
    rsp_word_t         rsp_word;

    delay_request_timer_table #(.SLOTS(SLOTS)) u_top (.*);

    // shadow copy of the timer table
    logic [RATE_W-1:0] rate_q;
    logic [31:0]       count_q;
    logic [31:0]       next_id_q;
    logic              slot_busy [SLOTS];
    logic [31:0]       slot_id   [SLOTS];
    logic [15:0]       slot_own  [SLOTS];
    logic [31:0]       slot_due  [SLOTS];

    rsp_word_t awaited_rsp[$];

    int send_idle_pct;
    int stall_pct;
    int mismatches;
    int words_sent;
    int results_seen;
    int expiries_seen;
    int full_replies;
    int quiet_cycles;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] ms;
        logic [15:0] who;
        bit          typed;
        logic [1:0]  kind;
        logic [31:0] value;
    } dir_row_t;

    dir_row_t dir_rows [DIRECTED_ROWS];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one accepted word to the shadow table and queue the words it causes.
    task automatic table_apply(input req_word_t w);
        logic [31:0] prod;
        logic [31:0] ticks;
        logic [31:0] id;
        rsp_word_t   r;
        int          n;
        bit          placed;
        n      = 0;
        id     = 32'd0;
        placed = 1'b0;
        r.dest_process = w.requester;
        r.value        = 32'd0;
        r.last         = 1'b1;
        case (w.opcode)
            OP_TICK:
            begin
                count_q = count_q + 32'd1;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (n < MAX_RESULTS && slot_busy[i] && slot_due[i] <= count_q)
                    begin
                        slot_busy[i]   = 1'b0;
                        r.kind         = KIND_EXPIRY;
                        r.dest_process = slot_own[i];
                        r.value        = slot_id[i];
                        r.last         = 1'b0;
                        awaited_rsp.push_back(r);
                        n++;
                    end
                end
                if (n > 0)
                begin
                    r      = awaited_rsp.pop_back();
                    r.last = 1'b1;
                    awaited_rsp.push_back(r);
                end
            end
            OP_DELAY:
            begin
                prod  = w.wait_ms * {18'd0, rate_q};
                ticks = prod / 32'(MS_PER_SECOND);
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!placed && !slot_busy[i])
                    begin
                        placed       = 1'b1;
                        id           = next_id_q;
                        next_id_q    = next_id_q + 32'd1;
                        slot_busy[i] = 1'b1;
                        slot_id[i]   = id;
                        slot_own[i]  = w.requester;
                        slot_due[i]  = count_q + ticks;
                    end
                end
                r.kind  = KIND_DELAY;
                r.value = id;
                awaited_rsp.push_back(r);
            end
            OP_READ:
            begin
                r.kind  = KIND_COUNT;
                r.value = count_q;
                awaited_rsp.push_back(r);
            end
            OP_IGNORE:
            begin
            end
            default:
            begin
                r.kind = KIND_REJECT;
                awaited_rsp.push_back(r);
            end
        endcase
    endtask

    task automatic send_word(input req_word_t w);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_word  <= w;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        words_sent++;
        table_apply(w);
    endtask

    // Drop valid, let every expected word arrive, then give the back end time to finish.
    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_tick_rate(input logic [31:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TICK_RATE;
        pwdata  <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rate_q = v[RATE_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_idle(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct = 31;
                stall_pct     = 83;
            end
            1:
            begin
                send_idle_pct = 83;
                stall_pct     = 31;
            end
            default:
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
        endcase
    endtask

    always @(negedge clk)
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        rsp_word_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            results_seen++;
            if (rsp_word.kind == KIND_EXPIRY)
                expiries_seen++;
            if (rsp_word.kind == KIND_DELAY && rsp_word.value == 32'd0)
                full_replies++;
            if (awaited_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: kind %0d dest %h value %h last %b",
                             rsp_word.kind, rsp_word.dest_process, rsp_word.value,
                             rsp_word.last);
            end
            else
            begin
                want = awaited_rsp.pop_front();
                if (rsp_word.kind != want.kind
                    || rsp_word.dest_process != want.dest_process
                    || rsp_word.value != want.value
                    || rsp_word.last != want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want %0d/%h/%h/%b got %0d/%h/%h/%b",
                                 want.kind, want.dest_process, want.value, want.last,
                                 rsp_word.kind, rsp_word.dest_process, rsp_word.value,
                                 rsp_word.last);
                end
            end
        end
    end

    // watchdog: cycles with no handshake on any port
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        req_word_t w;
        rsp_word_t r;
        int        seg_rate;
        int        bound;
        int        wild_left;
        int        pick;
        int        done;
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        req_valid <= 1'b0;
        req_word  <= '0;
        mismatches    = 0;
        words_sent    = 0;
        results_seen  = 0;
        expiries_seen = 0;
        full_replies  = 0;
        quiet_cycles  = 0;
        wild_left     = 6;
        rate_q        = RATE_RESET;
        count_q       = 32'd0;
        next_id_q     = 32'd1;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_busy[i] = 1'b0;
            slot_id[i]   = 32'd0;
            slot_own[i]  = 16'd0;
            slot_due[i]  = 32'd0;
        end
        set_idle(0);

        dir_rows[0]  = '{OP_READ,   32'h0000_0000, 16'h0000, 1'b1, KIND_COUNT,  32'd0};
        dir_rows[1]  = '{OP_TICK,   32'hFFFF_FFFF, 16'hFFFF, 1'b0, KIND_EXPIRY, 32'd0};
        dir_rows[2]  = '{OP_READ,   32'h0000_0000, 16'hFFFF, 1'b1, KIND_COUNT,  32'd1};
        dir_rows[3]  = '{OP_DELAY,  32'h0000_0000, 16'h1234, 1'b1, KIND_DELAY,  32'd1};
        dir_rows[4]  = '{OP_TICK,   32'h0000_0000, 16'h0000, 1'b0, KIND_EXPIRY, 32'd0};
        dir_rows[5]  = '{OP_DELAY,  32'hFFFF_FFFF, 16'hFFFF, 1'b1, KIND_DELAY,  32'd2};
        dir_rows[6]  = '{OP_DELAY,  32'd9,         16'h0000, 1'b0, KIND_DELAY,  32'd0};
        dir_rows[7]  = '{OP_DELAY,  32'd10,        16'h00FF, 1'b0, KIND_DELAY,  32'd0};
        dir_rows[8]  = '{OP_DELAY,  32'd25,        16'hFF00, 1'b0, KIND_DELAY,  32'd0};
        dir_rows[9]  = '{OP_IGNORE, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, KIND_DELAY,  32'd0};
        dir_rows[10] = '{OP_BAD_4,  32'h0000_0000, 16'h0000, 1'b1, KIND_REJECT, 32'd0};
        dir_rows[11] = '{OP_BAD_5,  32'hFFFF_FFFF, 16'hFFFF, 1'b1, KIND_REJECT, 32'd0};
        dir_rows[12] = '{OP_BAD_6,  32'h1234_5678, 16'hABCD, 1'b1, KIND_REJECT, 32'd0};
        dir_rows[13] = '{OP_BAD_7,  32'h0000_0000, 16'h5555, 1'b1, KIND_REJECT, 32'd0};
        dir_rows[14] = '{OP_TICK,   32'h0000_0000, 16'h0000, 1'b0, KIND_EXPIRY, 32'd0};
        dir_rows[15] = '{OP_TICK,   32'h0000_0000, 16'h0000, 1'b0, KIND_EXPIRY, 32'd0};
        dir_rows[16] = '{OP_READ,   32'h0000_0000, 16'h2222, 1'b0, KIND_COUNT,  32'd0};
        // product wraps to zero: expires on the very next tick
        dir_rows[17] = '{OP_DELAY,  32'h8000_0000, 16'h7777, 1'b0, KIND_DELAY,  32'd0};
        dir_rows[18] = '{OP_TICK,   32'h0000_0000, 16'h0000, 1'b0, KIND_EXPIRY, 32'd0};
        dir_rows[19] = '{OP_DELAY,  32'h5555_5555, 16'hAAAA, 1'b0, KIND_DELAY,  32'd0};
        dir_rows[20] = '{OP_DELAY,  32'hAAAA_AAAA, 16'h5555, 1'b0, KIND_DELAY,  32'd0};
        dir_rows[21] = '{OP_READ,   32'h0000_0000, 16'h0000, 1'b0, KIND_COUNT,  32'd0};
        dir_rows[22] = '{OP_TICK,   32'h0000_0000, 16'h0000, 1'b0, KIND_EXPIRY, 32'd0};
        dir_rows[23] = '{OP_IGNORE, 32'h0000_0000, 16'h0000, 1'b0, KIND_DELAY,  32'd0};
        dir_rows[24] = '{OP_DELAY,  32'd1,         16'h8000, 1'b0, KIND_DELAY,  32'd0};
        dir_rows[25] = '{OP_TICK,   32'h0000_0000, 16'h0000, 1'b0, KIND_EXPIRY, 32'd0};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < DIRECTED_ROWS; k++)
        begin
            w.opcode    = dir_rows[k].op;
            w.wait_ms   = dir_rows[k].ms;
            w.requester = dir_rows[k].who;
            send_word(w);
            if (dir_rows[k].typed)
            begin
                // hand-written expectation replaces the shadow's single word
                r       = awaited_rsp.pop_back();
                r.kind  = dir_rows[k].kind;
                r.value = dir_rows[k].value;
                awaited_rsp.push_back(r);
            end
        end

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_drained();
            case (seg)
                0:       seg_rate = 1;
                1:       seg_rate = 10000;
                2:       seg_rate = 16383;
                3:       seg_rate = 0;
                4:       seg_rate = $urandom_range(1, 10000);
                5:       seg_rate = 1000;
                6:       seg_rate = RATE_RESET;
                7:       seg_rate = $urandom_range(0, 16383);
                default: seg_rate = 250;
            endcase
            write_tick_rate(seg_rate);
            set_idle(seg / 3);
            bound = (seg_rate == 0) ? 50 : 12000 / seg_rate + 2;

            // fill past capacity so the table-full reply shows up, then ticks drain it
            if (seg % 3 == 0)
            begin
                for (int k = 0; k < FILL_WORDS; k++)
                begin
                    w.opcode    = OP_DELAY;
                    w.wait_ms   = (seg_rate > 333) ? 32'd0 : $urandom_range(0, 3);
                    w.requester = $urandom_range(0, 65535);
                    send_word(w);
                end
            end

            done = 0;
            while (done < SEG_WORDS)
            begin
                pick        = $urandom_range(0, 99);
                w.wait_ms   = $urandom;
                w.requester = $urandom_range(0, 65535);
                if (pick < 40)
                    w.opcode = OP_TICK;
                else if (pick < 72)
                begin
                    w.opcode = OP_DELAY;
                    // long delays never expire and hold a slot: keep them rare
                    if (wild_left > 0 && $urandom_range(0, 99) < 3)
                        wild_left--;
                    else
                        w.wait_ms = $urandom_range(0, bound);
                end
                else if (pick < 82)
                    w.opcode = OP_READ;
                else if (pick < 90)
                    w.opcode = OP_IGNORE;
                else
                    w.opcode = 3'($urandom_range(OP_BAD_4, OP_BAD_7));
                send_word(w);
                if (w.opcode != OP_IGNORE)
                    done++;
            end
        end

        wait_drained();
        if (awaited_rsp.size() != 0)
            mismatches++;
        $display("summary: %0d words sent over %0d rate settings, %0d results checked",
                 words_sent, SEGMENTS + 1, results_seen);
        $display("summary: %0d expiries, %0d table-full replies, %0d mismatches",
                 expiries_seen, full_replies, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
